### rtl/rhh_pkg.sv
// Shared types and constants for the Robin Hood hash table core.
// Depends on nothing; the core and the checker import it.
package rhh_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_AW  = 6;
    localparam int CAPACITY = SLOTS - SLOTS / 4;
    localparam int HASH_W   = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = 4;

    localparam logic [7:0] LIMIT_RESET = 8'd128;

    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_ERASE  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [2:0] ST_MISS     = 3'd0;
    localparam logic [2:0] ST_HIT      = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_MODIFIED = 3'd3;
    localparam logic [2:0] ST_ERASED   = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam logic [1:0] REG_FWD_LIMIT  = 2'd0;
    localparam logic [1:0] REG_DISP_LIMIT = 2'd1;
    localparam logic [1:0] REG_POLICY     = 2'd2;

    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [SLOT_AW-1:0] entry;
    } slot_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_word_t;

endpackage

### rtl/rhh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/robin_hood_hash_table_core.sv
// Top level of the Robin Hood hash table core: control sequencer, slot valid bits,
// configuration registers and result register. Uses rhh_pkg and two rhh_ram instances.
//
// Usage:
// Requests arrive on the req channel (mode, key, hash, value) under req_valid/req_ready.
// Each request produces exactly one result beat on the rsp channel (status, entry_index,
// value_out, entry_count, alarm) under rsp_valid/rsp_ready.
// The block works on one request at a time. Every slot read is a slot memory read and
// its evaluation, and a hash match adds an entry memory read. A new insert writes one
// slot more than the slots it displaces. An erase examines slots in a backward shift, and
// when the erased entry is not the last one in the dense store it also scans the slot
// memory for the slot that points to the last entry. The slot memory has a single read
// port, so slots are read one at a time. The result waits in an output register, so the
// next request is taken while an earlier result has not yet been picked up; a request
// finishes only once that register is free. Reset empties the table (all slot valid bits
// cleared), zeroes the entry count and the alarm, and loads the limit registers with 128
// and the occupied policy with 0. The slot and entry memories are not cleared; entries
// beyond the count are never read. Configuration is written over the APB-style port; the
// user must write it only while no request is in flight; the block does not enforce it.
module robin_hood_hash_table_core
    import rhh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         mode,
    input  logic [KEY_W-1:0]   key,
    input  logic [HASH_W-1:0]  hash,
    input  logic [VAL_W-1:0]   value,
    // result channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [2:0]         status,
    output logic [SLOT_AW-1:0] entry_index,
    output logic [VAL_W-1:0]   value_out,
    output logic [SLOT_AW-1:0] entry_count,
    output logic               alarm,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // One-hot sequencer states. RD states wait for the registered memory read,
    // EV states act on the data that came back.
    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_SRD  = 14'b00000000000010,
        S_SEV  = 14'b00000000000100,
        S_KRD  = 14'b00000000001000,
        S_KEV  = 14'b00000000010000,
        S_CRD  = 14'b00000000100000,
        S_CEV  = 14'b00000001000000,
        S_ERD  = 14'b00000010000000,
        S_ECP  = 14'b00000100000000,
        S_SCRD = 14'b00001000000000,
        S_SCEV = 14'b00010000000000,
        S_BRD  = 14'b00100000000000,
        S_BEV  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Latched request.
    logic [1:0]         mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic [VAL_W-1:0]   value_reg;

    // Walk state.
    logic [SLOT_AW-1:0] slot_addr_reg;
    logic [SLOT_AW-1:0] dist_reg;
    logic [SLOT_AW-1:0] ent_addr_reg;
    slot_word_t         carry_reg;
    logic [COUNT_W-1:0] disp_reg;
    logic               steal_reg;
    logic [SLOT_AW-1:0] erase_ent_reg;
    logic [SLOT_AW-1:0] last_reg;
    logic [SLOT_AW-1:0] prev_reg;
    logic [SLOT_AW-1:0] cnt_reg;

    // Table state kept in flip-flops.
    logic [SLOTS-1:0]   valid_reg;
    logic [COUNT_W-1:0] live_reg;
    logic               alarm_reg;

    // Configuration.
    logic [7:0]         fwd_limit_reg;
    logic [7:0]         disp_limit_reg;
    logic               policy_reg;

    // Pending result and output register.
    logic [2:0]         res_status_reg;
    logic [SLOT_AW-1:0] res_index_reg;
    logic [VAL_W-1:0]   res_value_reg;
    logic               rsp_valid_reg;
    logic [2:0]         status_reg;
    logic [SLOT_AW-1:0] index_reg;
    logic [VAL_W-1:0]   value_out_reg;
    logic [SLOT_AW-1:0] count_reg;
    logic               alarm_out_reg;

    // Memory ports.
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    slot_word_t         slot_wdata;
    slot_word_t         slot_q;
    logic               ent_we;
    logic [SLOT_AW-1:0] ent_waddr;
    entry_word_t        ent_wdata;
    entry_word_t        ent_q;

    rhh_ram #(
        .WIDTH($bits(slot_word_t)),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .raddr(slot_addr_reg),
        .rdata(slot_q)
    );

    rhh_ram #(
        .WIDTH($bits(entry_word_t)),
        .DEPTH(SLOTS)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ent_wdata),
        .raddr(ent_addr_reg),
        .rdata(ent_q)
    );

    // Decisions on the slot that was just read.
    logic               cur_valid;
    logic [SLOT_AW-1:0] cur_dist;
    logic               probe_stop;
    logic               hash_match;
    logic               key_match;
    logic               walk_end;
    logic               table_full;
    logic [COUNT_W-1:0] live_dec;
    logic               scan_hit;
    logic               shift_stop;
    logic               ins_alarm;
    logic               req_take;
    logic               rsp_load;
    logic               cfg_write;

    assign cur_valid  = valid_reg[slot_addr_reg];
    assign cur_dist   = slot_addr_reg - slot_q.hash[SLOT_AW-1:0];
    assign probe_stop = !cur_valid || (dist_reg > cur_dist);
    assign hash_match = slot_q.hash == hash_reg;
    assign key_match  = ent_q.key == key_reg;
    assign walk_end   = dist_reg == SLOT_AW'(SLOTS - 1);
    assign table_full = live_reg >= COUNT_W'(CAPACITY);
    assign live_dec   = live_reg - COUNT_W'(1);
    assign scan_hit   = cur_valid && (slot_q.entry == last_reg);
    assign shift_stop = !cur_valid || (cur_dist == '0);
    assign ins_alarm  = ({2'b00, dist_reg} >= fwd_limit_reg)
                     || (steal_reg && ({1'b0, disp_reg} >= disp_limit_reg));
    assign req_take   = (state_reg == S_IDLE) && req_valid;
    assign rsp_load   = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);
    assign cfg_write  = psel && penable && pwrite;

    // Memory write ports and next state.
    always_comb
    begin
        state_next = state_reg;
        slot_we    = 1'b0;
        slot_waddr = slot_addr_reg;
        slot_wdata = carry_reg;
        ent_we     = 1'b0;
        ent_waddr  = live_reg[SLOT_AW-1:0];
        ent_wdata  = '{key: key_reg, value: value_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (mode == MODE_CLEAR) ? S_DONE : S_SRD;
                end
            end
            S_SRD:
            begin
                state_next = S_SEV;
            end
            S_SEV:
            begin
                if (probe_stop)
                begin
                    if (mode_reg == MODE_INSERT && !table_full)
                    begin
                        // New entry goes to the end of the dense store.
                        ent_we     = 1'b1;
                        state_next = S_CRD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (hash_match)
                begin
                    state_next = S_KRD;
                end
                else
                begin
                    state_next = walk_end ? S_DONE : S_SRD;
                end
            end
            S_KRD:
            begin
                state_next = S_KEV;
            end
            S_KEV:
            begin
                if (key_match)
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        ent_we     = !policy_reg;
                        ent_waddr  = ent_addr_reg;
                        ent_wdata  = '{key: ent_q.key, value: value_reg};
                        state_next = S_DONE;
                    end
                    else if (mode_reg == MODE_ERASE)
                    begin
                        if (ent_addr_reg != live_dec[SLOT_AW-1:0])
                        begin
                            state_next = S_ERD;
                        end
                        else
                        begin
                            state_next = (live_dec == '0) ? S_DONE : S_BRD;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = walk_end ? S_DONE : S_SRD;
                end
            end
            S_CRD:
            begin
                state_next = S_CEV;
            end
            S_CEV:
            begin
                // Drop the carried slot here and pick up the occupant, if any.
                slot_we    = 1'b1;
                state_next = cur_valid ? S_CRD : S_DONE;
            end
            S_ERD:
            begin
                state_next = S_ECP;
            end
            S_ECP:
            begin
                // The last entry moves into the hole left by the erased one.
                ent_we     = 1'b1;
                ent_waddr  = erase_ent_reg;
                ent_wdata  = ent_q;
                state_next = S_SCRD;
            end
            S_SCRD:
            begin
                state_next = S_SCEV;
            end
            S_SCEV:
            begin
                if (scan_hit)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = '{hash: slot_q.hash, entry: erase_ent_reg};
                end
                if (scan_hit || slot_addr_reg == SLOT_AW'(SLOTS - 1))
                begin
                    state_next = (live_reg == '0) ? S_DONE : S_BRD;
                end
                else
                begin
                    state_next = S_SCRD;
                end
            end
            S_BRD:
            begin
                state_next = S_BEV;
            end
            S_BEV:
            begin
                if (shift_stop)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_waddr = prev_reg;
                    slot_wdata = slot_q;
                    state_next = (cnt_reg == SLOT_AW'(SLOTS - 2)) ? S_DONE : S_BRD;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_FIND;
            key_reg        <= '0;
            hash_reg       <= '0;
            value_reg      <= '0;
            slot_addr_reg  <= '0;
            dist_reg       <= '0;
            ent_addr_reg   <= '0;
            carry_reg      <= '0;
            disp_reg       <= '0;
            steal_reg      <= 1'b0;
            erase_ent_reg  <= '0;
            last_reg       <= '0;
            prev_reg       <= '0;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            live_reg       <= '0;
            alarm_reg      <= 1'b0;
            fwd_limit_reg  <= LIMIT_RESET;
            disp_limit_reg <= LIMIT_RESET;
            policy_reg     <= 1'b0;
            res_status_reg <= ST_MISS;
            res_index_reg  <= '0;
            res_value_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            status_reg     <= ST_MISS;
            index_reg      <= '0;
            value_out_reg  <= '0;
            count_reg      <= '0;
            alarm_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_FWD_LIMIT:  fwd_limit_reg  <= pwdata[7:0];
                    REG_DISP_LIMIT: disp_limit_reg <= pwdata[7:0];
                    REG_POLICY:     policy_reg     <= pwdata[0];
                    default:        ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        mode_reg      <= mode;
                        key_reg       <= key;
                        hash_reg      <= hash;
                        value_reg     <= value;
                        slot_addr_reg <= hash[SLOT_AW-1:0];
                        dist_reg      <= '0;
                        if (mode == MODE_CLEAR)
                        begin
                            valid_reg      <= '0;
                            live_reg       <= '0;
                            alarm_reg      <= 1'b0;
                            res_status_reg <= ST_CLEARED;
                            res_index_reg  <= '0;
                            res_value_reg  <= '0;
                        end
                    end
                end
                S_SEV:
                begin
                    if (probe_stop)
                    begin
                        if (mode_reg == MODE_INSERT && !table_full)
                        begin
                            live_reg       <= live_reg + COUNT_W'(1);
                            carry_reg      <= '{hash: hash_reg,
                                                entry: live_reg[SLOT_AW-1:0]};
                            steal_reg      <= cur_valid;
                            disp_reg       <= '0;
                            res_status_reg <= ST_INSERTED;
                            res_index_reg  <= live_reg[SLOT_AW-1:0];
                            res_value_reg  <= value_reg;
                        end
                        else
                        begin
                            res_status_reg <= (mode_reg == MODE_INSERT) ? ST_FULL : ST_MISS;
                            res_index_reg  <= '0;
                            res_value_reg  <= '0;
                        end
                    end
                    else if (hash_match)
                    begin
                        ent_addr_reg <= slot_q.entry;
                    end
                    else
                    begin
                        slot_addr_reg <= slot_addr_reg + SLOT_AW'(1);
                        dist_reg      <= dist_reg + SLOT_AW'(1);
                        res_status_reg <= (mode_reg == MODE_INSERT) ? ST_FULL : ST_MISS;
                        res_index_reg  <= '0;
                        res_value_reg  <= '0;
                    end
                end
                S_KEV:
                begin
                    if (key_match)
                    begin
                        res_index_reg <= ent_addr_reg;
                        if (mode_reg == MODE_INSERT)
                        begin
                            res_status_reg <= ST_MODIFIED;
                            res_value_reg  <= policy_reg ? ent_q.value : value_reg;
                        end
                        else if (mode_reg == MODE_ERASE)
                        begin
                            res_status_reg           <= ST_ERASED;
                            res_value_reg            <= ent_q.value;
                            valid_reg[slot_addr_reg] <= 1'b0;
                            erase_ent_reg            <= ent_addr_reg;
                            last_reg                 <= live_dec[SLOT_AW-1:0];
                            live_reg                 <= live_dec;
                            prev_reg                 <= slot_addr_reg;
                            cnt_reg                  <= '0;
                            if (ent_addr_reg != live_dec[SLOT_AW-1:0])
                            begin
                                ent_addr_reg <= live_dec[SLOT_AW-1:0];
                            end
                            else
                            begin
                                slot_addr_reg <= slot_addr_reg + SLOT_AW'(1);
                            end
                        end
                        else
                        begin
                            res_status_reg <= ST_HIT;
                            res_value_reg  <= ent_q.value;
                        end
                    end
                    else
                    begin
                        slot_addr_reg  <= slot_addr_reg + SLOT_AW'(1);
                        dist_reg       <= dist_reg + SLOT_AW'(1);
                        res_status_reg <= (mode_reg == MODE_INSERT) ? ST_FULL : ST_MISS;
                        res_index_reg  <= '0;
                        res_value_reg  <= '0;
                    end
                end
                S_CEV:
                begin
                    if (cur_valid)
                    begin
                        carry_reg     <= slot_q;
                        disp_reg      <= disp_reg + COUNT_W'(1);
                        slot_addr_reg <= slot_addr_reg + SLOT_AW'(1);
                    end
                    else
                    begin
                        valid_reg[slot_addr_reg] <= 1'b1;
                        if (ins_alarm)
                        begin
                            alarm_reg <= 1'b1;
                        end
                    end
                end
                S_ECP:
                begin
                    slot_addr_reg <= '0;
                end
                S_SCEV:
                begin
                    if (scan_hit || slot_addr_reg == SLOT_AW'(SLOTS - 1))
                    begin
                        slot_addr_reg <= prev_reg + SLOT_AW'(1);
                    end
                    else
                    begin
                        slot_addr_reg <= slot_addr_reg + SLOT_AW'(1);
                    end
                end
                S_BEV:
                begin
                    if (!shift_stop)
                    begin
                        valid_reg[prev_reg]      <= 1'b1;
                        valid_reg[slot_addr_reg] <= 1'b0;
                        prev_reg                 <= slot_addr_reg;
                        slot_addr_reg            <= slot_addr_reg + SLOT_AW'(1);
                        cnt_reg                  <= cnt_reg + SLOT_AW'(1);
                    end
                end
                default:
                begin
                end
            endcase

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                status_reg    <= res_status_reg;
                index_reg     <= res_index_reg;
                value_out_reg <= res_value_reg;
                count_reg     <= live_reg[SLOT_AW-1:0];
                alarm_out_reg <= alarm_reg;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            REG_FWD_LIMIT:  prdata = {24'd0, fwd_limit_reg};
            REG_DISP_LIMIT: prdata = {24'd0, disp_limit_reg};
            REG_POLICY:     prdata = {31'd0, policy_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign pready      = 1'b1;
    assign req_ready   = state_reg == S_IDLE;
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign entry_index = index_reg;
    assign value_out   = value_out_reg;
    assign entry_count = count_reg;
    assign alarm       = alarm_out_reg;

endmodule

### rtl/rhh_checker.sv
// Port-level checks for the Robin Hood hash table core, bound to the top level.
// Depends on rhh_pkg and robin_hood_hash_table_core.
module rhh_checker
    import rhh_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [2:0]         status,
    input logic [SLOT_AW-1:0] entry_index,
    input logic [VAL_W-1:0]   value_out,
    input logic [SLOT_AW-1:0] entry_count,
    input logic               alarm
);

    // A stalled result beat stays valid and holds its status and value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(value_out))
        else $error("result beat changed while stalled");

    // A clear leaves an empty table with the alarm dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_CLEARED |->
            entry_count == '0 && !alarm && entry_index == '0 && value_out == '0)
        else $error("clear result not empty");

    // Miss and full report neither an entry nor a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_MISS || status == ST_FULL) |->
            entry_index == '0 && value_out == '0)
        else $error("miss or full carries data");

    // Entry count never passes three quarters of the slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= SLOT_AW'(CAPACITY) && status <= ST_CLEARED)
        else $error("result out of range");

endmodule

bind robin_hood_hash_table_core rhh_checker u_rhh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .entry_index(entry_index),
    .value_out  (value_out),
    .entry_count(entry_count),
    .alarm      (alarm)
);
